// ----- rtl/core/tmcw_pkg.sv -----
// Shared types, character codes and cursor state for the text mode console writer.
package tmcw_pkg;

	// Default screen geometry
	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 24;

	// Widths of the cursor fields, the wrap compare, the cell address and the address product
	localparam int CUR_W  = 8;
	localparam int CMP_W  = 9;
	localparam int ADDR_W = 11;
	localparam int PROD_W = 17;

	// Character codes
	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	// Sequence terminators: letters strictly between 'a' and 'z'
	localparam logic [7:0] SEQ_END_LO  = 8'h62;
	localparam logic [7:0] SEQ_END_HI  = 8'h79;

	// Escape parser modes
	localparam logic [1:0] MODE_TEXT      = 2'd0;
	localparam logic [1:0] MODE_AFTER_ESC = 2'd1;
	localparam logic [1:0] MODE_SEQUENCE  = 2'd2;
	localparam logic [1:0] MODE_UNUSED    = 2'd3;

	// One input character transfer
	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] attribute;
		logic       first;
		logic [6:0] start_col;
		logic [4:0] start_row;
	} char_t;

	// One cell write
	typedef struct packed {
		logic [10:0] cell_addr;
		logic [15:0] cell_data;
	} cell_t;

	// Cursor and escape state
	typedef struct packed {
		logic [CUR_W-1:0] col;
		logic [CUR_W-1:0] row;
		logic [1:0]       mode;
	} cursor_t;

endpackage

// ----- rtl/core/text_mode_console_writer.sv -----
// Top level of the text mode console writer: input stage, cursor state, output register.
//
// Usage: the char channel (char_valid, char_ready, char_item) carries one
// character byte with its attribute, a first-of-string flag and a start
// position. Printable bytes leave on the cell channel (cell_valid,
// cell_ready, cell_item) as a cell index and attribute/character word.
// Newline, ESC and bytes of an escape or control sequence produce no transfer.
// Order: a byte accepted into the input stage register is processed into the
// cursor and output registers, and its cell write is then valid at cell_valid.
// Throughput: one byte per cycle while no cell write stalls; the cursor update
// is combinational from the input stage into the cursor and output registers.
// Reset clears the cursor to the top-left cell and the parser to plain text;
// the input stage and output register come up empty.
// Stall: while a cell write waits on cell_ready, one more byte is held in
// the input stage; a byte that writes no cell still moves on, after that
// char_ready drops until the receiver takes the pending cell.
module text_mode_console_writer #(
	parameter int COLS = tmcw_pkg::COLS_DEF,
	parameter int ROWS = tmcw_pkg::ROWS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	output logic            char_ready,
	input  tmcw_pkg::char_t char_item,
	output logic            cell_valid,
	input  logic            cell_ready,
	output tmcw_pkg::cell_t cell_item
);

	logic              valid_s1;
	tmcw_pkg::char_t   item_s1;
	tmcw_pkg::cursor_t cursor_q;
	tmcw_pkg::cursor_t cursor_nxt;
	tmcw_pkg::cell_t   cell_nxt;
	logic              emit;
	logic              advance;

	// Move the staged byte on unless its cell write has no room
	assign advance    = valid_s1 && (!emit || !cell_valid || cell_ready);
	assign char_ready = !valid_s1 || advance;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			item_s1 <= char_item;
		end
	end

	tmcw_step #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_step (
		.item   (item_s1),
		.cur    (cursor_q),
		.nxt    (cursor_nxt),
		.emit   (emit),
		.cell_wr(cell_nxt)
	);

	// Advance the cursor and parser state with each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q.col  <= '0;
			cursor_q.row  <= '0;
			cursor_q.mode <= tmcw_pkg::MODE_TEXT;
		end else if (advance) begin
			cursor_q <= cursor_nxt;
		end
	end

	tmcw_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.load_cell (cell_nxt),
		.cell_valid(cell_valid),
		.cell_ready(cell_ready),
		.cell_item (cell_item)
	);

	// Cursor always stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cursor_q.col) < COLS) && (32'(cursor_q.row) < ROWS))
		else $error("cursor left the screen");

	// Parser never reaches the unused mode
	a_mode_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q.mode != tmcw_pkg::MODE_UNUSED)
		else $error("escape parser in unused mode");

	// State holds while no byte moves on
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cursor_q))
		else $error("cursor changed without a processed byte");

endmodule

// ----- rtl/core/tmcw_step.sv -----
// Per-character step logic: cursor load, escape parsing, cell write and cursor advance.
module tmcw_step #(
	parameter int COLS = tmcw_pkg::COLS_DEF,
	parameter int ROWS = tmcw_pkg::ROWS_DEF
) (
	input  tmcw_pkg::char_t   item,
	input  tmcw_pkg::cursor_t cur,
	output tmcw_pkg::cursor_t nxt,
	output logic              emit,
	output tmcw_pkg::cell_t   cell_wr
);

	localparam logic [tmcw_pkg::CMP_W-1:0] COLS_C = tmcw_pkg::CMP_W'(COLS);
	localparam logic [tmcw_pkg::CMP_W-1:0] ROWS_C = tmcw_pkg::CMP_W'(ROWS);

	logic [tmcw_pkg::CMP_W-1:0]  col_ld, row_ld;
	logic [tmcw_pkg::CMP_W-1:0]  col_w1, row_w1, row_inc1;
	logic [tmcw_pkg::CMP_W-1:0]  col_a, row_a;
	logic [tmcw_pkg::CMP_W-1:0]  col_w2, row_w2, row_inc2;
	logic [tmcw_pkg::PROD_W-1:0] addr_full;
	logic [1:0]                  mode_nxt;

	// Load the cursor from the start fields on the first byte of a string
	always_comb begin
		if (item.first) begin
			col_ld = tmcw_pkg::CMP_W'(item.start_col);
			row_ld = tmcw_pkg::CMP_W'(item.start_row);
		end else begin
			col_ld = tmcw_pkg::CMP_W'(cur.col);
			row_ld = tmcw_pkg::CMP_W'(cur.row);
		end
	end

	// Wrap the loaded cursor onto the screen
	assign row_inc1 = row_ld + tmcw_pkg::CMP_W'(1);
	always_comb begin
		col_w1 = col_ld;
		row_w1 = row_ld;
		if (col_ld >= COLS_C) begin
			col_w1 = '0;
			row_w1 = row_inc1;
		end
		if (row_w1 >= ROWS_C) begin
			col_w1 = '0;
			row_w1 = '0;
		end
	end

	// Cell index for a printable byte
	assign addr_full = tmcw_pkg::PROD_W'(row_w1) * tmcw_pkg::PROD_W'(COLS)
		+ tmcw_pkg::PROD_W'(col_w1);
	assign cell_wr.cell_addr = addr_full[tmcw_pkg::ADDR_W-1:0];
	assign cell_wr.cell_data = {item.attribute, item.ch};

	// Parse escapes and advance the cursor in text mode
	always_comb begin
		mode_nxt = tmcw_pkg::MODE_TEXT;
		emit     = 1'b0;
		col_a    = col_w1;
		row_a    = row_w1;
		case (cur.mode)
			tmcw_pkg::MODE_SEQUENCE: begin
				if (item.ch inside {[tmcw_pkg::SEQ_END_LO : tmcw_pkg::SEQ_END_HI]}) begin
					mode_nxt = tmcw_pkg::MODE_TEXT;
				end else begin
					mode_nxt = tmcw_pkg::MODE_SEQUENCE;
				end
			end
			tmcw_pkg::MODE_AFTER_ESC: begin
				if (item.ch == tmcw_pkg::CH_LBRACKET) begin
					mode_nxt = tmcw_pkg::MODE_SEQUENCE;
				end else begin
					mode_nxt = tmcw_pkg::MODE_TEXT;
				end
			end
			default: begin
				if (item.ch == tmcw_pkg::CH_ESC) begin
					mode_nxt = tmcw_pkg::MODE_AFTER_ESC;
				end else if (item.ch == tmcw_pkg::CH_NEWLINE) begin
					col_a = '0;
					row_a = row_w1 + tmcw_pkg::CMP_W'(1);
				end else begin
					emit  = 1'b1;
					col_a = col_w1 + tmcw_pkg::CMP_W'(1);
				end
			end
		endcase
	end

	// Wrap again after the advance
	assign row_inc2 = row_a + tmcw_pkg::CMP_W'(1);
	always_comb begin
		col_w2 = col_a;
		row_w2 = row_a;
		if (col_a >= COLS_C) begin
			col_w2 = '0;
			row_w2 = row_inc2;
		end
		if (row_w2 >= ROWS_C) begin
			col_w2 = '0;
			row_w2 = '0;
		end
	end

	assign nxt.col  = col_w2[tmcw_pkg::CUR_W-1:0];
	assign nxt.row  = row_w2[tmcw_pkg::CUR_W-1:0];
	assign nxt.mode = mode_nxt;

endmodule

// ----- rtl/core/tmcw_out_reg.sv -----
// Output register for cell writes with valid and ready toward the frame buffer.
module tmcw_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  tmcw_pkg::cell_t load_cell,
	output logic            cell_valid,
	input  logic            cell_ready,
	output tmcw_pkg::cell_t cell_item
);

	logic            valid_q;
	tmcw_pkg::cell_t cell_q;

	// Hold the valid flag until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (cell_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Capture a new cell write
	always_ff @(posedge clk) begin
		if (load) begin
			cell_q <= load_cell;
		end
	end

	assign cell_valid = valid_q;
	assign cell_item  = cell_q;

endmodule

// ----- tb/text_mode_console_writer_tb.sv -----
// Self-checking testbench for the text mode console writer: cursor, wrap and escape handling.
`timescale 1ns / 1ps

module text_mode_console_writer_tb;

	localparam int SCREEN_COLS = tmcw_pkg::COLS_DEF;
	localparam int SCREEN_ROWS = tmcw_pkg::ROWS_DEF;
	localparam int RANDOM_CHARS = 650;

	logic            clk        = 1'b0;
	logic            arst_n     = 1'b0;
	logic            char_valid = 1'b0;
	logic            char_ready;
	tmcw_pkg::char_t char_item  = '0;
	logic            cell_valid;
	logic            cell_ready = 1'b0;
	tmcw_pkg::cell_t cell_item;

	// Stimulus and expected cell writes
	tmcw_pkg::char_t pending_chars[$];
	tmcw_pkg::cell_t expected_cells[$];

	// Cursor state mirrored by the predictor
	int         cur_col  = 0;
	int         cur_row  = 0;
	logic [1:0] esc_mode = tmcw_pkg::MODE_TEXT;

	// Sender burst shaping
	int burst_left = 1;
	int gap_left   = 0;

	// Receiver stall shaping
	int         stall_style      = 0;
	int         stall_phase_left = 0;
	logic [7:0] stall_pattern    = 8'hFF;

	// String builder state
	bit         lead_flag = 1'b0;
	logic [6:0] lead_col  = '0;
	logic [4:0] lead_row  = '0;
	int         counted   = 0;

	int              mismatch_count = 0;
	tmcw_pkg::cell_t want;

	text_mode_console_writer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.cell_item  (cell_item)
	);

	always #4 clk = ~clk;

	// Fold an out-of-range cursor back onto the screen
	task automatic wrap_cursor();
		if (cur_col >= SCREEN_COLS) begin
			cur_col = 0;
			cur_row = cur_row + 1;
		end
		if (cur_row >= SCREEN_ROWS) begin
			cur_row = 0;
			cur_col = 0;
		end
	endtask

	// Advance the cursor and parser for one transfer, queue the cell it writes
	task automatic predict_cell(input tmcw_pkg::char_t c);
		tmcw_pkg::cell_t wr;
		if (c.first) begin
			cur_col = int'(c.start_col);
			cur_row = int'(c.start_row);
			wrap_cursor();
		end
		case (esc_mode)
			tmcw_pkg::MODE_SEQUENCE: begin
				if (c.ch >= tmcw_pkg::SEQ_END_LO && c.ch <= tmcw_pkg::SEQ_END_HI)
					esc_mode = tmcw_pkg::MODE_TEXT;
			end
			tmcw_pkg::MODE_AFTER_ESC: begin
				esc_mode = (c.ch == tmcw_pkg::CH_LBRACKET) ? tmcw_pkg::MODE_SEQUENCE
					: tmcw_pkg::MODE_TEXT;
			end
			default: begin
				esc_mode = tmcw_pkg::MODE_TEXT;
				if (c.ch == tmcw_pkg::CH_ESC) begin
					esc_mode = tmcw_pkg::MODE_AFTER_ESC;
				end else if (c.ch == tmcw_pkg::CH_NEWLINE) begin
					cur_col = 0;
					cur_row = cur_row + 1;
				end else begin
					wr.cell_addr = tmcw_pkg::ADDR_W'(cur_row * SCREEN_COLS + cur_col);
					wr.cell_data = {c.attribute, c.ch};
					expected_cells.push_back(wr);
					cur_col = cur_col + 1;
				end
				wrap_cursor();
			end
		endcase
	endtask

	// Open a new string at the given start position
	task automatic start_string(input int col, input int row);
		lead_flag = 1'b1;
		lead_col  = 7'(col);
		lead_row  = 5'(row);
	endtask

	// Queue one character; start fields are random unless a string opens here
	task automatic push_char(input logic [7:0] c, input logic [7:0] attr, input bit counts);
		tmcw_pkg::char_t item;
		item.ch        = c;
		item.attribute = attr;
		item.first     = lead_flag;
		item.start_col = lead_flag ? lead_col : 7'($urandom_range(0, 127));
		item.start_row = lead_flag ? lead_row : 5'($urandom_range(0, 31));
		lead_flag = 1'b0;
		pending_chars.push_back(item);
		if (counts)
			counted++;
	endtask

	// Queue an escape sequence with a random parameter body
	task automatic push_sequence();
		int n;
		n = $urandom_range(0, 4);
		push_char(tmcw_pkg::CH_ESC, 8'($urandom_range(0, 255)), 1'b1);
		push_char(tmcw_pkg::CH_LBRACKET, 8'($urandom_range(0, 255)), 1'b1);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				push_char(8'h3B, 8'($urandom_range(0, 255)), 1'b1);
			else
				push_char(8'($urandom_range(8'h30, 8'h39)), 8'($urandom_range(0, 255)), 1'b1);
		end
		push_char(8'($urandom_range(tmcw_pkg::SEQ_END_LO, tmcw_pkg::SEQ_END_HI)),
			8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic note_mismatch(input string field, input int exp_val, input int got_val);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
				$realtime, field, exp_val, got_val);
	endtask

	// Sender: present transfers in bursts, predict each one as it is accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && char_ready)
				predict_cell(char_item);
			if (!char_valid || char_ready) begin
				if (gap_left > 0) begin
					gap_left   <= gap_left - 1;
					char_valid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					char_item  <= pending_chars.pop_front();
					char_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: switch between stall styles from phase to phase
	always @(posedge clk) begin
		if (stall_phase_left == 0) begin
			stall_style      <= $urandom_range(0, 3);
			stall_phase_left <= $urandom_range(20, 120);
			stall_pattern    <= 8'($urandom_range(1, 255));
		end else begin
			stall_phase_left <= stall_phase_left - 1;
			stall_pattern    <= {stall_pattern[6:0], stall_pattern[7]};
		end
		case (stall_style)
			0: cell_ready <= 1'b1;
			1: cell_ready <= 1'($urandom_range(0, 1));
			2: cell_ready <= ($urandom_range(0, 3) == 0);
			default: cell_ready <= stall_pattern[7];
		endcase
	end

	// Monitor: compare each cell transfer with the oldest expected write
	always @(posedge clk) begin
		if (arst_n && cell_valid && cell_ready) begin
			if (expected_cells.size() == 0) begin
				note_mismatch("unexpected cell_addr", 0, int'(cell_item.cell_addr));
			end else begin
				want = expected_cells.pop_front();
				if (cell_item.cell_addr !== want.cell_addr)
					note_mismatch("cell_addr", int'(want.cell_addr),
						int'(cell_item.cell_addr));
				if (cell_item.cell_data !== want.cell_data)
					note_mismatch("cell_data", int'(want.cell_data),
						int'(cell_item.cell_data));
			end
		end
	end

	initial begin
		int kind;
		int len;
		int sub;

		// Directed: corners of the screen and fields
		start_string(0, 0);
		push_char(8'h41, 8'h00, 1'b1);
		push_char(8'hFF, 8'hFF, 1'b1);
		push_char(8'h00, 8'h5A, 1'b1);          // zero byte prints like any other
		push_char(8'h01, 8'hA5, 1'b1);
		push_char(tmcw_pkg::CH_NEWLINE, 8'h11, 1'b1);
		push_char(8'h7E, 8'h22, 1'b1);
		start_string(SCREEN_COLS - 1, SCREEN_ROWS - 1);
		push_char(8'h78, 8'h33, 1'b1);          // last cell, then wrap to the top
		push_char(8'h79, 8'h44, 1'b1);
		// Start positions off the screen
		start_string(127, 31);
		push_char(8'h42, 8'h55, 1'b1);
		start_string(SCREEN_COLS, 5);
		push_char(8'h43, 8'h66, 1'b1);
		start_string(10, SCREEN_ROWS);
		push_char(8'h44, 8'h77, 1'b1);
		// Escape swallows one byte
		push_char(tmcw_pkg::CH_ESC, 8'h88, 1'b1);
		push_char(8'h51, 8'h99, 1'b0);
		push_char(8'h45, 8'hAA, 1'b1);
		// Control sequence; 'a' and 'z' do not end it, 'b' does
		push_char(tmcw_pkg::CH_ESC, 8'hBB, 1'b1);
		push_char(tmcw_pkg::CH_LBRACKET, 8'hCC, 1'b0);
		push_char(8'h31, 8'hDD, 1'b0);
		push_char(8'h61, 8'hEE, 1'b0);
		push_char(8'h7A, 8'h0F, 1'b0);
		push_char(tmcw_pkg::SEQ_END_LO, 8'hF0, 1'b0);
		push_char(tmcw_pkg::CH_ESC, 8'h12, 1'b1);
		push_char(tmcw_pkg::CH_LBRACKET, 8'h34, 1'b0);
		push_char(tmcw_pkg::SEQ_END_HI, 8'h56, 1'b0);
		// Escape at the end of one string eats the head of the next
		push_char(tmcw_pkg::CH_ESC, 8'h78, 1'b1);
		start_string(3, 3);
		push_char(8'h46, 8'h9A, 1'b0);
		push_char(8'h47, 8'hBC, 1'b1);
		// Newline on the bottom row
		start_string(5, SCREEN_ROWS - 1);
		push_char(tmcw_pkg::CH_NEWLINE, 8'hDE, 1'b1);
		push_char(8'h48, 8'hF1, 1'b1);

		// Random: mostly well-formed strings, some raw noise
		counted = 0;
		while (counted < RANDOM_CHARS) begin
			kind = $urandom_range(0, 99);
			if (kind < 85) begin
				if ($urandom_range(0, 9) == 0)
					start_string($urandom_range(0, 127), $urandom_range(0, 31));
				else
					start_string($urandom_range(0, SCREEN_COLS - 1),
						$urandom_range(0, SCREEN_ROWS - 1));
				len = $urandom_range(1, 16);
				repeat (len) begin
					sub = $urandom_range(0, 99);
					if (sub < 70)
						push_char(8'($urandom_range(8'h20, 8'h7E)),
							8'($urandom_range(0, 255)), 1'b1);
					else if (sub < 80)
						push_char(tmcw_pkg::CH_NEWLINE, 8'($urandom_range(0, 255)), 1'b1);
					else if (sub < 90)
						push_sequence();
					else begin
						push_char(tmcw_pkg::CH_ESC, 8'($urandom_range(0, 255)), 1'b1);
						push_char(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), 1'b1);
					end
				end
			end else begin
				lead_flag = 1'($urandom_range(0, 1));
				lead_col  = 7'($urandom_range(0, 127));
				lead_row  = 5'($urandom_range(0, 31));
				repeat ($urandom_range(1, 6))
					push_char(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), 1'b1);
			end
		end

		// Release reset, then wait for all transfers to drain
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_chars.size() != 0 || char_valid)
			@(posedge clk);
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Hold a hard limit on the run
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/tmcw_pkg.sv
rtl/core/tmcw_step.sv
rtl/core/tmcw_out_reg.sv
rtl/core/text_mode_console_writer.sv
tb/text_mode_console_writer_tb.sv
